// File: rtl/srs_pkg.sv
// shared types and constants for the shutter relay sequencer
// used by srs_ctrl, srs_datapath and shutter_relay_sequencer; no dependencies

package srs_pkg;

    // default number of shutter channels
    localparam int CHANNELS_DEF = 4;

    // maximum phase evaluations per channel and tick
    localparam int EVALS_PER_TICK = 6;

    // field widths
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 2;
    localparam int DIR_W     = 2;
    localparam int WAIT_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int PHASE_W   = 3;
    localparam int MASK_W    = 4;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_DRIVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ENABLE = 2'd2;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // phase codes of the per-channel machine
    localparam logic [PHASE_W-1:0] PH_STOPPED      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DIR          = 3'd1;
    localparam logic [PHASE_W-1:0] PH_POWER        = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DRIVE        = 3'd3;
    localparam logic [PHASE_W-1:0] PH_REMOVE_POWER = 3'd4;
    localparam logic [PHASE_W-1:0] PH_REMOVE_DIR   = 3'd5;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_DIR_SETTLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_RELEASE = 1'd1;
    localparam logic [CFG_W-1:0]     DIR_SETTLE_RST    = 8'd10;
    localparam logic [CFG_W-1:0]     POWER_RELEASE_RST = 8'd10;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // latch input item, clear events, set index
        logic apply;     // apply drive or enable command
        logic eval;      // one phase evaluation at current index
        logic idx_inc;   // move to next channel
        logic idx_chan;  // point index at the addressed channel
        logic load_out;  // load the result register
    } srs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic cont;       // evaluation chains into another one
        logic last_chan;  // index is at the last channel
    } srs_status_t;

endpackage

// File: rtl/srs_datapath.sv
// per-channel state, phase evaluation unit, command application and result register
// depends on srs_pkg

module srs_datapath #(
    parameter int CHANNELS = srs_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [srs_pkg::S_DATA_W-1:0]    in_data,
    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]       cfg_wdata,
    input  srs_pkg::srs_cmd_t               cmd,
    output srs_pkg::srs_status_t            status,
    output logic [srs_pkg::M_DATA_W-1:0]    out_data
);

    localparam int IDXW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MASKN = (CHANNELS < srs_pkg::MASK_W) ? CHANNELS : srs_pkg::MASK_W;

    // per-channel state
    logic [srs_pkg::PHASE_W-1:0] phase_reg   [CHANNELS];
    logic [srs_pkg::DIR_W-1:0]   cur_reg     [CHANNELS];
    logic [srs_pkg::DIR_W-1:0]   pend_reg    [CHANNELS];
    logic [srs_pkg::WAIT_W-1:0]  wait_reg    [CHANNELS];
    logic                        enabled_reg [CHANNELS];
    logic                        power_reg   [CHANNELS];
    logic                        dirrel_reg  [CHANNELS];

    // latched input item
    logic [srs_pkg::OP_W-1:0]   op_reg;
    logic [srs_pkg::CHAN_W-1:0] chan_reg;
    logic [srs_pkg::DIR_W-1:0]  dir_reg;
    logic                       en_reg;

    logic [srs_pkg::CFG_W-1:0]  settle_reg;
    logic [srs_pkg::CFG_W-1:0]  release_reg;
    logic [IDXW-1:0]            idx_reg;
    logic [IDXW-1:0]            idx_next;
    logic [srs_pkg::MASK_W-1:0] started_reg;
    logic [srs_pkg::MASK_W-1:0] stopped_reg;
    logic [srs_pkg::MASK_W-1:0] started_next;
    logic [srs_pkg::MASK_W-1:0] stopped_next;
    logic [srs_pkg::M_DATA_W-1:0] out_reg;

    // channel decode for the incoming and the latched item
    logic [4:0]      in_chan_w;
    logic            in_chan_ok;
    logic [IDXW-1:0] in_chan_idx;
    logic [4:0]      chan_w;
    logic            chan_ok;
    logic [IDXW-1:0] chan_idx;
    logic [4:0]      idx_w;

    assign in_chan_w   = 5'(in_data[3:2]);
    assign in_chan_ok  = in_chan_w < 5'(CHANNELS);
    assign in_chan_idx = in_chan_ok ? in_chan_w[IDXW-1:0] : '0;
    assign chan_w      = 5'(chan_reg);
    assign chan_ok     = chan_w < 5'(CHANNELS);
    assign chan_idx    = chan_ok ? chan_w[IDXW-1:0] : '0;
    assign idx_w       = 5'(idx_reg);

    // state of the selected channel
    logic [srs_pkg::PHASE_W-1:0] ph;
    logic [srs_pkg::DIR_W-1:0]   cd;
    logic [srs_pkg::DIR_W-1:0]   pd;
    logic [srs_pkg::WAIT_W-1:0]  wc;
    logic                        pr;
    logic                        dr;
    logic                        enf;

    assign ph  = phase_reg[idx_reg];
    assign cd  = cur_reg[idx_reg];
    assign pd  = pend_reg[idx_reg];
    assign wc  = wait_reg[idx_reg];
    assign pr  = power_reg[idx_reg];
    assign dr  = dirrel_reg[idx_reg];
    assign enf = enabled_reg[idx_reg];

    // phase evaluation unit
    logic [srs_pkg::PHASE_W-1:0] ph_n;
    logic [srs_pkg::DIR_W-1:0]   cd_n;
    logic [srs_pkg::WAIT_W-1:0]  wc_n;
    logic                        pr_n;
    logic                        dr_n;
    logic                        ev_start;
    logic                        ev_stop;
    logic                        cont;
    logic                        changed;

    always_comb begin
        ph_n     = ph;
        cd_n     = cd;
        wc_n     = wc;
        pr_n     = pr;
        dr_n     = dr;
        ev_start = 1'b0;
        ev_stop  = 1'b0;
        cont     = 1'b0;
        changed  = cd != pd;
        case (ph)
            srs_pkg::PH_STOPPED: begin
                if (changed) begin
                    cd_n = pd;
                    if (pd != srs_pkg::DIR_STOP) begin
                        ph_n = srs_pkg::PH_DIR;
                        wc_n = '0;
                        cont = 1'b1;
                    end
                end
            end
            srs_pkg::PH_DIR: begin
                if (changed) begin
                    // abort while settling never reaches the power phase
                    ph_n = (wc != '0) ? srs_pkg::PH_REMOVE_DIR : srs_pkg::PH_STOPPED;
                    cont = 1'b1;
                end else if (wc == '0 && cd != srs_pkg::DIR_UP && cd != srs_pkg::DIR_DOWN) begin
                    // invalid direction forces power off
                    cd_n = srs_pkg::DIR_STOP;
                    ph_n = srs_pkg::PH_REMOVE_POWER;
                    wc_n = '0;
                    cont = 1'b1;
                end else begin
                    if (wc == '0) begin
                        dr_n = (cd == srs_pkg::DIR_DOWN);
                    end
                    if (wc >= settle_reg) begin
                        wc_n = '0;
                        ph_n = srs_pkg::PH_POWER;
                        cont = 1'b1;
                    end else begin
                        wc_n = wc + 8'd1;
                    end
                end
            end
            srs_pkg::PH_POWER: begin
                if (changed) begin
                    ph_n = srs_pkg::PH_REMOVE_DIR;
                    cont = 1'b1;
                end else begin
                    pr_n     = 1'b1;
                    ph_n     = srs_pkg::PH_DRIVE;
                    ev_start = 1'b1;
                end
            end
            srs_pkg::PH_DRIVE: begin
                if (changed) begin
                    ph_n = srs_pkg::PH_REMOVE_POWER;
                    wc_n = '0;
                    cont = 1'b1;
                end
            end
            srs_pkg::PH_REMOVE_POWER: begin
                if (wc == '0) begin
                    pr_n    = 1'b0;
                    ev_stop = 1'b1;
                end
                if (wc >= release_reg) begin
                    wc_n = '0;
                    ph_n = srs_pkg::PH_REMOVE_DIR;
                    cont = 1'b1;
                end else begin
                    wc_n = wc + 8'd1;
                end
            end
            srs_pkg::PH_REMOVE_DIR: begin
                dr_n = 1'b0;
                ph_n = srs_pkg::PH_STOPPED;
                cont = 1'b1;
            end
            default: begin
                cont = 1'b0;
            end
        endcase
    end

    assign status.cont      = cont;
    assign status.last_chan = idx_reg == IDXW'(CHANNELS - 1);

    // drive and enable commands for the addressed channel
    logic                      cmd_pend_we;
    logic [srs_pkg::DIR_W-1:0] cmd_pend_val;

    always_comb begin
        cmd_pend_we  = 1'b0;
        cmd_pend_val = dir_reg;
        if (chan_ok) begin
            if (op_reg == srs_pkg::OP_DRIVE) begin
                cmd_pend_we = enf;
            end else if (op_reg == srs_pkg::OP_ENABLE) begin
                cmd_pend_we  = enf && !en_reg;
                cmd_pend_val = srs_pkg::DIR_STOP;
            end
        end
    end

    // index and event masks
    always_comb begin
        idx_next     = idx_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        if (cmd.load) begin
            idx_next     = (in_data[1:0] == srs_pkg::OP_TICK) ? '0 : in_chan_idx;
            started_next = '0;
            stopped_next = '0;
        end else begin
            if (cmd.idx_inc) begin
                idx_next = idx_reg + IDXW'(1);
            end else if (cmd.idx_chan) begin
                idx_next = chan_idx;
            end
            if (cmd.eval && idx_w < 5'(srs_pkg::MASK_W)) begin
                if (ev_start) begin
                    started_next[idx_w[1:0]] = 1'b1;
                end
                if (ev_stop) begin
                    stopped_next[idx_w[1:0]] = 1'b1;
                end
            end
        end
    end

    // control registers, configuration and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= srs_pkg::DIR_SETTLE_RST;
            release_reg <= srs_pkg::POWER_RELEASE_RST;
            idx_reg     <= '0;
            started_reg <= '0;
            stopped_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                phase_reg[i]   <= srs_pkg::PH_STOPPED;
                cur_reg[i]     <= srs_pkg::DIR_STOP;
                pend_reg[i]    <= srs_pkg::DIR_STOP;
                wait_reg[i]    <= '0;
                enabled_reg[i] <= 1'b0;
                power_reg[i]   <= 1'b0;
                dirrel_reg[i]  <= 1'b0;
            end
        end else begin
            idx_reg     <= idx_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
            if (cfg_we && cfg_index == srs_pkg::REG_DIR_SETTLE) begin
                settle_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == srs_pkg::REG_POWER_RELEASE) begin
                release_reg <= cfg_wdata;
            end
            if (cmd.eval) begin
                phase_reg[idx_reg]  <= ph_n;
                cur_reg[idx_reg]    <= cd_n;
                wait_reg[idx_reg]   <= wc_n;
                power_reg[idx_reg]  <= pr_n;
                dirrel_reg[idx_reg] <= dr_n;
            end
            if (cmd.apply) begin
                if (cmd_pend_we) begin
                    pend_reg[idx_reg] <= cmd_pend_val;
                end
                if (chan_ok && op_reg == srs_pkg::OP_ENABLE) begin
                    enabled_reg[idx_reg] <= en_reg;
                end
            end
        end
    end

    // input item latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_data[1:0];
            chan_reg <= in_data[3:2];
            dir_reg  <= in_data[5:4];
            en_reg   <= in_data[6];
        end
    end

    // result assembly
    logic [srs_pkg::MASK_W-1:0] pmask;
    logic [srs_pkg::MASK_W-1:0] dmask;
    logic                       idle;
    logic [srs_pkg::DIR_W-1:0]  rep;

    always_comb begin
        pmask = '0;
        dmask = '0;
        idle  = 1'b1;
        for (int i = 0; i < MASKN; i++) begin
            pmask[i] = power_reg[i];
            dmask[i] = dirrel_reg[i];
        end
        for (int i = 0; i < CHANNELS; i++) begin
            if (!(phase_reg[i] == srs_pkg::PH_STOPPED && cur_reg[i] == srs_pkg::DIR_STOP)) begin
                idle = 1'b0;
            end
        end
        // pending direction shows while the current direction is stop
        rep = (cd == srs_pkg::DIR_STOP) ? pd : cd;
        if (rep != srs_pkg::DIR_UP && rep != srs_pkg::DIR_DOWN) begin
            rep = srs_pkg::DIR_STOP;
        end
        if (!chan_ok) begin
            rep = srs_pkg::DIR_STOP;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {5'd0, rep, idle, stopped_reg, started_reg, dmask, pmask};
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/srs_ctrl.sv
// controller state machine: accepts items, steps the evaluation unit over channels
// and phases, and hands results to the output register; depends on srs_pkg

module srs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 in_is_tick,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output srs_pkg::srs_cmd_t    cmd,
    input  srs_pkg::srs_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CMD    = 4'b0010,
        S_EVAL   = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    localparam logic [2:0] LAST_EVAL = 3'(srs_pkg::EVALS_PER_TICK - 1);

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = in_is_tick ? S_EVAL : S_CMD;
                end
            end
            S_CMD: begin
                cmd.apply  = 1'b1;
                state_next = S_REPORT;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (status.cont && cnt_reg != LAST_EVAL) begin
                    cnt_next = cnt_reg + 3'd1;
                end else begin
                    cnt_next = '0;
                    if (status.last_chan) begin
                        cmd.idx_chan = 1'b1;
                        state_next   = S_REPORT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // evaluation count stays within the per-tick bound
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EVAL |-> cnt_reg <= LAST_EVAL)
        else $error("evaluation count out of range");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REPORT && out_valid_reg && !m_tready) |=> state_reg == S_REPORT)
        else $error("result register overwritten");

    // an accepted item always leads to work before the next accept
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg != S_IDLE)
        else $error("controller idle right after transfer");

    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result load while output busy");

endmodule

// File: rtl/shutter_relay_sequencer.sv
// top level of the shutter relay sequencer: stream ports, configuration port,
// controller and datapath; depends on srs_pkg, srs_ctrl and srs_datapath

// A drive or enable item goes from transfer to result in order: accept, apply,
// load of the result register, held off while an earlier result waits.
// A tick runs one shared phase evaluation unit once per cycle, channel after
// channel, each channel taking 1 to 6 evaluations as its phases chain. The next
// item is taken the cycle after its predecessor's result is loaded, while that
// result may still wait on the output. Writes to the two timing registers take
// effect at once and belong in idle periods. Only channels 0 to 3 appear in the
// result masks.

module shutter_relay_sequencer #(
    parameter int CHANNELS = srs_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op [1:0], channel [3:2], direction [5:4], enable_value [6], zero [7]
    input  logic [srs_pkg::S_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // power_mask [3:0], dir_mask [7:4], started_mask [11:8], stopped_mask [15:12],
    // all_idle [16], reported_direction [18:17], zero [23:19]
    output logic [srs_pkg::M_DATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]       cfg_wdata
);

    srs_pkg::srs_cmd_t    cmd;
    srs_pkg::srs_status_t status;
    logic                 in_is_tick;

    assign in_is_tick = s_tdata[1:0] == srs_pkg::OP_TICK;

    // sequencing control
    srs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_is_tick (in_is_tick),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .status     (status)
    );

    // channel state and evaluation
    srs_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule
